[hdl/ftdsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftdsc_pkg
// Types and constants shared by the frame time debt skip controller.
// ----------------------------------------------------------------------------
package ftdsc_pkg;

   localparam int MODE_W      = 2;
   localparam int AMOUNT_W    = 16;
   localparam int LIMIT_W     = 9;
   localparam int RATE_W      = 8;
   localparam int DEBT_W      = 32;
   localparam int FT_W        = 10;
   localparam int PERIOD_W    = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int PER_W  = FT_W + PERIOD_W;
   localparam int PROD_W = PER_W + RATE_W;
   localparam int MS_W   = AMOUNT_W + FT_W;

   // serial multiplier: multiplier consumed DIGIT_W bits per cycle
   localparam int MUL_A_W = PER_W;
   localparam int MUL_B_W = AMOUNT_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIGIT_W = 2;

   localparam logic [FT_W-1:0]     FT_RESET     = 10'd33;
   localparam logic [RATE_W-1:0]   MAX_RESET    = 8'd4;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd30;

   typedef enum logic [MODE_W-1:0] {
      MODE_BEGIN        = 2'd0,
      MODE_REPAY_FRAMES = 2'd1,
      MODE_REPAY_TIME   = 2'd2,
      MODE_END          = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_TIME   = 2'd0,
      CSR_MAX_RATE     = 2'd1,
      CSR_REPAY_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_rsp_type;

endpackage
`default_nettype wire

[hdl/ftdsc_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftdsc_req_if
// Event word channel: mode, amount and caller rate limit.
// ----------------------------------------------------------------------------
interface ftdsc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ftdsc_pkg::MODE_W-1:0]         mode;
   logic [ftdsc_pkg::AMOUNT_W-1:0]       amount;
   logic signed [ftdsc_pkg::LIMIT_W-1:0] repay_limit;

   modport source (output valid, mode, amount, repay_limit, input ready);
   modport sink   (input valid, mode, amount, repay_limit, output ready);
endinterface
`default_nettype wire

[hdl/ftdsc_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftdsc_rsp_if
// Result word channel: rate, capped rate and time debt.
// ----------------------------------------------------------------------------
interface ftdsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ftdsc_pkg::RATE_W-1:0]        repay_rate;
   logic [ftdsc_pkg::RATE_W-1:0]        capped_rate;
   logic signed [ftdsc_pkg::DEBT_W-1:0] time_debt;

   modport source (output valid, repay_rate, capped_rate, time_debt, input ready);
   modport sink   (input valid, repay_rate, capped_rate, time_debt, output ready);
endinterface
`default_nettype wire

[hdl/ftdsc_sermul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftdsc_sermul
// Digit-serial unsigned multiplier. The multiplier shifts out DIGIT_W bits
// per cycle; finishes as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ftdsc_sermul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ftdsc_pkg::mul_req_type mul_req,
   output      ftdsc_pkg::mul_rsp_type mul_rsp
);
   import ftdsc_pkg::*;

   logic               busy_ff, busy_in;
   logic [MUL_P_W-1:0] mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [MUL_P_W-1:0] partial;
   logic               done;

   assign done = busy_ff && (mplier_ff == '0);

   always_comb begin
      partial = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         if (mplier_ff[i]) begin
            partial = partial + (mcand_ff << i);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         mcand_in  = {{(MUL_P_W-MUL_A_W){1'b0}}, mul_req.a};
         mplier_in = mul_req.b;
         acc_in    = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         acc_in    = acc_ff + partial;
         mcand_in  = mcand_ff << DIGIT_W;
         mplier_in = mplier_ff >> DIGIT_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mul_rsp.done    = done;
   assign mul_rsp.product = acc_ff;

endmodule
`default_nettype wire

[hdl/frame_time_debt_skip_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frame_time_debt_skip_controller
// Frame pacing controller: time debt, repay rate and repaid flag.
// ----------------------------------------------------------------------------
// One event word in, one result word out. Events are handled one at a time;
// the input takes a new word once the previous one has moved to the output
// register, even while that result still waits. All products go through one
// serial multiplier that retires two multiplier bits per cycle and stops when
// the remaining bits are zero. Begin frame with debt below one frame time
// skips the multiplier; otherwise it forms frame time times repay period and
// then that product times rate before adjusting the rate. Repay frames forms
// frame time times amount before the repay step. Register writes take effect
// at once and are seen by any later step of an event in progress.
// ----------------------------------------------------------------------------
module frame_time_debt_skip_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ftdsc_req_if.sink                                req,
   ftdsc_rsp_if.source                              rsp,
   input  wire logic                                csr_we,
   input  wire logic [ftdsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ftdsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ftdsc_pkg::*;

   localparam int EXT_W = DEBT_W + 2;
   localparam logic signed [EXT_W-1:0] DEBT_MAX_EXT = 34'sh0_7FFF_FFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PER_WAIT,
      S_PROD_WAIT,
      S_RATE,
      S_MS_WAIT,
      S_REPAY,
      S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [FT_W-1:0]            ft_ff, ft_in;
   logic [RATE_W-1:0]          maxr_ff, maxr_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic signed [DEBT_W-1:0]   debt_ff, debt_in;
   logic [RATE_W-1:0]          rate_ff, rate_in;
   logic                       flag_ff, flag_in;
   logic signed [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [PER_W-1:0]           per_ff, per_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [MS_W-1:0]            ms_ff, ms_in;
   mul_req_type                mul_req_ff, mul_req_in;
   mul_rsp_type                mul_rsp;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]          rsp_rate_ff, rsp_rate_in;
   logic [RATE_W-1:0]          rsp_capped_ff, rsp_capped_in;
   logic signed [DEBT_W-1:0]   rsp_debt_ff, rsp_debt_in;

   logic signed [EXT_W-1:0]    debt_ext, amount_ext, ft_ext, ms_ext;
   logic signed [EXT_W-1:0]    debt_sum, debt_diff, debt_floor;
   logic [DEBT_W-1:0]          debt_pos;
   logic [PROD_W-1:0]          prod_dec;
   logic                       rate_inc, rate_dec;
   logic [RATE_W:0]            rate_next;
   logic                       req_take;

   ftdsc_sermul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;

   assign debt_ext   = {{2{debt_ff[DEBT_W-1]}}, debt_ff};
   assign amount_ext = {{(EXT_W-AMOUNT_W){1'b0}}, req.amount};
   assign ft_ext     = {{(EXT_W-FT_W){1'b0}}, ft_ff};
   assign ms_ext     = {{(EXT_W-MS_W){1'b0}}, ms_ff};
   assign debt_sum   = debt_ext + amount_ext;
   assign debt_diff  = debt_ext - ms_ext;
   assign debt_floor = -ft_ext;

   // debt is known nonnegative while the rate is adjusted
   assign debt_pos = {1'b0, debt_ff[DEBT_W-2:0]};
   assign prod_dec = prod_ff - {{(PROD_W-PER_W){1'b0}}, per_ff};
   assign rate_inc = {{(DEBT_W-PROD_W){1'b0}}, prod_ff} < debt_pos;
   assign rate_dec = !rate_inc && (rate_ff > 8'd1)
                     && ({{(DEBT_W-PROD_W){1'b0}}, prod_dec} > debt_pos);

   always_comb begin
      if (rate_inc) begin
         rate_next = {1'b0, rate_ff} + 9'd1;
      end else if (rate_dec) begin
         rate_next = {1'b0, rate_ff} - 9'd1;
      end else begin
         rate_next = {1'b0, rate_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      ft_in         = ft_ff;
      maxr_in       = maxr_ff;
      period_in     = period_ff;
      debt_in       = debt_ff;
      rate_in       = rate_ff;
      flag_in       = flag_ff;
      limit_in      = limit_ff;
      per_in        = per_ff;
      prod_in       = prod_ff;
      ms_in         = ms_ff;
      mul_req_in    = mul_req_ff;
      mul_req_in.start = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_rate_in   = rsp_rate_ff;
      rsp_capped_in = rsp_capped_ff;
      rsp_debt_in   = rsp_debt_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_TIME:   ft_in     = csr_wdata[FT_W-1:0];
            CSR_MAX_RATE:     maxr_in   = csr_wdata[RATE_W-1:0];
            CSR_REPAY_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               limit_in = req.repay_limit;
               case (mode_type'(req.mode))
                  MODE_BEGIN: begin
                     flag_in = 1'b0;
                     debt_in = (debt_sum > DEBT_MAX_EXT) ? DEBT_MAX_EXT[DEBT_W-1:0]
                                                         : debt_sum[DEBT_W-1:0];
                     if (debt_sum < ft_ext) begin
                        rate_in  = '0;
                        state_in = S_DONE;
                     end else begin
                        mul_req_in.start = 1'b1;
                        mul_req_in.a     = {{(MUL_A_W-FT_W){1'b0}}, ft_ff};
                        mul_req_in.b     = {{(MUL_B_W-PERIOD_W){1'b0}}, period_ff};
                        state_in         = S_PER_WAIT;
                     end
                  end
                  MODE_REPAY_FRAMES: begin
                     mul_req_in.start = 1'b1;
                     mul_req_in.a     = {{(MUL_A_W-FT_W){1'b0}}, ft_ff};
                     mul_req_in.b     = req.amount;
                     state_in         = S_MS_WAIT;
                  end
                  MODE_REPAY_TIME: begin
                     ms_in    = {{(MS_W-AMOUNT_W){1'b0}}, req.amount};
                     state_in = S_REPAY;
                  end
                  MODE_END: begin
                     if (!flag_ff) begin
                        debt_in = '0;
                        rate_in = '0;
                        flag_in = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_PER_WAIT: begin
            if (mul_rsp.done) begin
               per_in           = mul_rsp.product[PER_W-1:0];
               mul_req_in.start = 1'b1;
               mul_req_in.a     = mul_rsp.product[MUL_A_W-1:0];
               mul_req_in.b     = {{(MUL_B_W-RATE_W){1'b0}}, rate_ff};
               state_in         = S_PROD_WAIT;
            end
         end
         S_PROD_WAIT: begin
            if (mul_rsp.done) begin
               prod_in  = mul_rsp.product[PROD_W-1:0];
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            rate_in  = (rate_next > {1'b0, maxr_ff}) ? maxr_ff : rate_next[RATE_W-1:0];
            state_in = S_DONE;
         end
         S_MS_WAIT: begin
            if (mul_rsp.done) begin
               ms_in    = mul_rsp.product[MS_W-1:0];
               state_in = S_REPAY;
            end
         end
         S_REPAY: begin
            debt_in  = (debt_diff < debt_floor) ? debt_floor[DEBT_W-1:0]
                                                : debt_diff[DEBT_W-1:0];
            flag_in  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = rate_ff;
               rsp_debt_in   = debt_ff;
               rsp_capped_in = (!limit_ff[LIMIT_W-1] && (rate_ff > limit_ff[RATE_W-1:0]))
                               ? limit_ff[RATE_W-1:0] : rate_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         ft_ff            <= FT_RESET;
         maxr_ff          <= MAX_RESET;
         period_ff        <= PERIOD_RESET;
         debt_ff          <= '0;
         rate_ff          <= '0;
         flag_ff          <= 1'b1;
         mul_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         ft_ff            <= ft_in;
         maxr_ff          <= maxr_in;
         period_ff        <= period_in;
         debt_ff          <= debt_in;
         rate_ff          <= rate_in;
         flag_ff          <= flag_in;
         mul_req_ff.start <= mul_req_in.start;
         rsp_valid_ff     <= rsp_valid_in;
      end
      mul_req_ff.a  <= mul_req_in.a;
      mul_req_ff.b  <= mul_req_in.b;
      limit_ff      <= limit_in;
      per_ff        <= per_in;
      prod_ff       <= prod_in;
      ms_ff         <= ms_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_capped_ff <= rsp_capped_in;
      rsp_debt_ff   <= rsp_debt_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.repay_rate  = rsp_rate_ff;
   assign rsp.capped_rate = rsp_capped_ff;
   assign rsp.time_debt   = rsp_debt_ff;

endmodule
`default_nettype wire
